[rtl/fmds_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// fmds_pkg: shared constants, types and functions
// Widths, the CORDIC angle table and the types that pass between the
// discriminator front end, the CORDIC cells and the slicer.
// ============================================================================
package fmds_pkg;

   localparam int SAMPLE_WIDTH_DEF  = 16;
   localparam int SUM_WIDTH_DEF     = 24;
   localparam int CORDIC_STAGES_DEF = 14;
   localparam int ANGLE_WIDTH       = 16;
   localparam int SPS_WIDTH         = 6;
   localparam logic [SPS_WIDTH-1:0] SPS_RESET = 6'd2;
   localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 16'd16384;

   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;

   // Side information that travels with a sample through the CORDIC row.
   typedef struct packed {
      logic has_phase;
      logic last;
   } tag_type;

   // Rounded atan(2^-k) with pi scaled to 32768.
   function automatic angle_type atan_entry(input int k);
      angle_type v;
      v = '0;
      case (k)
         0:  v = 16'sd8192;
         1:  v = 16'sd4836;
         2:  v = 16'sd2555;
         3:  v = 16'sd1297;
         4:  v = 16'sd651;
         5:  v = 16'sd326;
         6:  v = 16'sd163;
         7:  v = 16'sd81;
         8:  v = 16'sd41;
         9:  v = 16'sd20;
         10: v = 16'sd10;
         11: v = 16'sd5;
         12: v = 16'sd3;
         13: v = 16'sd1;
         14: v = 16'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/fmds_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// fmds_req_if / fmds_rsp_if: valid/ready channels
// One interface for requests (I/Q samples) and one for sliced results.
// ============================================================================
interface fmds_req_if #(parameter int SAMPLE_WIDTH = fmds_pkg::SAMPLE_WIDTH_DEF);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] i_sample;
   logic signed [SAMPLE_WIDTH-1:0] q_sample;
   logic                           last_of_burst;
   modport source (output valid, i_sample, q_sample, last_of_burst, input ready);
   modport sink   (input valid, i_sample, q_sample, last_of_burst, output ready);
endinterface

interface fmds_rsp_if #(parameter int SUM_WIDTH = fmds_pkg::SUM_WIDTH_DEF);
   logic                        valid;
   logic                        ready;
   logic                        bit_res;
   logic signed [SUM_WIDTH-1:0] soft_sum;
   logic                        last_of_run;
   logic                        end_of_burst;
   modport source (output valid, bit_res, soft_sum, last_of_run, end_of_burst,
                   input ready);
   modport sink   (input valid, bit_res, soft_sum, last_of_run, end_of_burst,
                   output ready);
endinterface

[rtl/fmds_cordic_cell.sv]
`timescale 1ns / 1ps
// ============================================================================
// fmds_cordic_cell: one CORDIC vectoring micro-rotation
// Rotates the vector toward the real axis by atan(2^-STAGE) and accumulates
// the angle; registered, advancing when the row advances.
// ============================================================================
module fmds_cordic_cell #(
   parameter int VEC_WIDTH = 34,
   parameter int STAGE     = 0
) (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [VEC_WIDTH-1:0]       x_from,
   input  logic signed [VEC_WIDTH-1:0]       y_from,
   input  fmds_pkg::angle_type               z_from,
   output logic signed [VEC_WIDTH-1:0]       x_out,
   output logic signed [VEC_WIDTH-1:0]       y_out,
   output fmds_pkg::angle_type               z_out
);

   logic signed [VEC_WIDTH-1:0] x_ff, y_ff, x_in, y_in;
   fmds_pkg::angle_type         z_ff, z_in;

   // Micro-rotation: direction follows the sign of y.
   always_comb begin
      if (!y_from[VEC_WIDTH-1]) begin
         x_in = x_from + (y_from >>> STAGE);
         y_in = y_from - (x_from >>> STAGE);
         z_in = z_from + fmds_pkg::atan_entry(STAGE);
      end else begin
         x_in = x_from - (y_from >>> STAGE);
         y_in = y_from + (x_from >>> STAGE);
         z_in = z_from - fmds_pkg::atan_entry(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

[rtl/fmds_slicer.sv]
`timescale 1ns / 1ps
// ============================================================================
// fmds_slicer: run splitting, group integration and hold stage
// Takes one phase per request and produces up to three results, which are
// sent out one per cycle while rsp.ready is high, from a small result buffer.
// ============================================================================
module fmds_slicer #(
   parameter int SUM_WIDTH = fmds_pkg::SUM_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [fmds_pkg::SPS_WIDTH-1:0]    sps_cfg,
   input  logic                              in_valid,
   input  fmds_pkg::angle_type               in_phase,
   input  fmds_pkg::tag_type                 in_tag,
   output logic                              in_ready,
   fmds_rsp_if.source                        rsp
);

   localparam int SW = SUM_WIDTH;
   localparam int CW = fmds_pkg::SPS_WIDTH;
   localparam logic signed [SW:0] SAT_HI = (SW+1)'((64'sd1 <<< (SW-1)) - 1);
   localparam logic signed [SW:0] SAT_LO = -SAT_HI - (SW+1)'(1);

   function automatic logic signed [SW-1:0] sat_add(
      input logic signed [SW-1:0] a, input logic signed [SW-1:0] b);
      logic signed [SW:0] s;
      s = {a[SW-1], a} + {b[SW-1], b};
      if (s > SAT_HI) return SAT_HI[SW-1:0];
      if (s < SAT_LO) return SAT_LO[SW-1:0];
      return s[SW-1:0];
   endfunction

   // State registers.
   fmds_pkg::angle_type     prev_phase_ff, prev_phase_in;
   logic                    phase_valid_ff, phase_valid_in;
   logic signed [SW-1:0]    group_sum_ff, group_sum_in;
   logic [CW-1:0]           group_count_ff, group_count_in;
   logic signed [SW-1:0]    held_sum_ff, held_sum_in;
   logic                    held_valid_ff, held_valid_in;

   // Result buffer: up to three results of one request, sent in order.
   logic signed [SW-1:0] rb_sum_ff [3], rb_sum_in [3];
   logic [2:0]           rb_eob_ff, rb_eob_in;
   logic [1:0]           rb_cnt_ff, rb_cnt_in, rb_pos_ff, rb_pos_in;

   logic [CW-1:0]        sps;
   logic                 take, rb_empty, rb_done;
   logic signed [SW-1:0] pext;

   assign sps      = (sps_cfg == '0) ? CW'(1) : sps_cfg;
   assign rb_empty = (rb_cnt_ff == 2'd0);
   assign rb_done  = rsp.valid && rsp.ready && (rb_pos_ff + 2'd1 == rb_cnt_ff);
   assign in_ready = rb_empty || rb_done;
   assign take     = in_valid && in_ready;
   assign pext     = SW'(in_phase);

   // Per-request integration and emission.
   always_comb begin
      logic signed [SW-1:0] gs, hs;
      logic [CW-1:0]        gc;
      logic                 hv;
      logic [1:0]           n;
      gs = group_sum_ff; gc = group_count_ff;
      hs = held_sum_ff;  hv = held_valid_ff;
      n  = '0;
      for (int j = 0; j < 3; j++) rb_sum_in[j] = rb_sum_ff[j];
      rb_eob_in = rb_eob_ff;
      prev_phase_in  = prev_phase_ff;
      phase_valid_in = phase_valid_ff;
      rb_cnt_in = rb_cnt_ff;
      rb_pos_in = rb_pos_ff;
      if (rsp.valid && rsp.ready) begin
         if (rb_done) begin
            rb_cnt_in = '0;
            rb_pos_in = '0;
         end else begin
            rb_pos_in = rb_pos_ff + 2'd1;
         end
      end
      if (take) begin
         rb_eob_in = '0;
         if (in_tag.has_phase) begin
            if (phase_valid_ff &&
                ((!in_phase[15] && in_phase != '0 && (prev_phase_ff[15] ||
                  prev_phase_ff == '0)) ||
                 (in_phase[15] && !prev_phase_ff[15]))) begin
               if (gc == CW'(1) && hv) begin
                  hs = sat_add(hs, gs);
               end else begin
                  if (hv) begin
                     rb_sum_in[n] = hs;
                     n = n + 2'd1;
                  end
                  hs = gs;
                  hv = 1'b1;
               end
               gs = '0; gc = '0;
            end
            if (gc >= sps) begin
               if (hv) begin
                  rb_sum_in[n] = hs;
                  n = n + 2'd1;
               end
               hs = gs; hv = 1'b1;
               gs = '0; gc = '0;
            end
            gs = sat_add(gs, pext);
            gc = gc + CW'(1);
            prev_phase_in  = in_phase;
            phase_valid_in = 1'b1;
         end
         if (in_tag.last) begin
            if (hv) begin
               rb_sum_in[n] = hs;
               n = n + 2'd1;
            end
            if (gc != '0) begin
               rb_sum_in[n] = gs;
               n = n + 2'd1;
            end
            if (n != '0) rb_eob_in[n-2'd1] = 1'b1;
            gs = '0; gc = '0; hs = '0; hv = 1'b0;
            prev_phase_in = '0; phase_valid_in = 1'b0;
         end
         rb_cnt_in = n;
         rb_pos_in = '0;
      end
      group_sum_in = gs; group_count_in = gc;
      held_sum_in  = hs; held_valid_in  = hv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff  <= '0;
         phase_valid_ff <= 1'b0;
         group_sum_ff   <= '0;
         group_count_ff <= '0;
         held_sum_ff    <= '0;
         held_valid_ff  <= 1'b0;
         rb_cnt_ff      <= '0;
         rb_pos_ff      <= '0;
         rb_eob_ff      <= '0;
      end else begin
         prev_phase_ff  <= prev_phase_in;
         phase_valid_ff <= phase_valid_in;
         group_sum_ff   <= group_sum_in;
         group_count_ff <= group_count_in;
         held_sum_ff    <= held_sum_in;
         held_valid_ff  <= held_valid_in;
         rb_cnt_ff      <= rb_cnt_in;
         rb_pos_ff      <= rb_pos_in;
         rb_eob_ff      <= rb_eob_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) rb_sum_ff[j] <= rb_sum_in[j];
   end

   // Output selection from the buffer.
   assign rsp.valid        = !rb_empty;
   assign rsp.soft_sum     = rb_sum_ff[rb_pos_ff];
   assign rsp.bit_res      = !rb_sum_ff[rb_pos_ff][SW-1];
   assign rsp.last_of_run  = (rb_pos_ff + 2'd1 == rb_cnt_ff);
   assign rsp.end_of_burst = rb_eob_ff[rb_pos_ff];

endmodule

[rtl/fm_discriminator_symbol_slicer_core.sv]
`timescale 1ns / 1ps
// Path: product, pre-rotation and CORDIC cell registers, then the slicer's result buffer.
// Throughput: one request per cycle while each request yields at most one result
// and the output is ready; a request that yields two or three results holds the
// slicer's result buffer until the single output port has sent them all.
// Reset: synchronous; clears the pipeline valids, all run state, and sets
// samples_per_symbol to 2.
// ============================================================================
// fm_discriminator_symbol_slicer_core: FM discriminator and symbol slicer
// Conjugate product of adjacent samples, a row of CORDIC cells for the angle,
// and an integrate-and-dump slicer with run splitting at phase sign changes.
// ============================================================================
module fm_discriminator_symbol_slicer_core #(
   parameter int SAMPLE_WIDTH  = fmds_pkg::SAMPLE_WIDTH_DEF,
   parameter int SUM_WIDTH     = fmds_pkg::SUM_WIDTH_DEF,
   parameter int CORDIC_STAGES = fmds_pkg::CORDIC_STAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [fmds_pkg::SPS_WIDTH-1:0] csr_write_data,
   fmds_req_if.sink                       req,
   fmds_rsp_if.source                     rsp
);

   localparam int PW = 2 * SAMPLE_WIDTH + 1;    // exact product sum width
   localparam int VW = PW + 2;                  // CORDIC growth headroom
   localparam int NS = CORDIC_STAGES;
   localparam int DEPTH = NS + 2;               // product, pre-rotate, cells

   logic [fmds_pkg::SPS_WIDTH-1:0] sps_ff;
   logic advance, sl_ready, sl_valid;

   // Previous sample of the burst.
   logic signed [SAMPLE_WIDTH-1:0] prev_i_ff, prev_q_ff;
   logic                           prev_valid_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) sps_ff <= fmds_pkg::SPS_RESET;
      else if (csr_write_enable) sps_ff <= csr_write_data;
   end

   // Valid and tag of every pipeline slot; the row advances when the end drains.
   logic              vld_ff [DEPTH];
   fmds_pkg::tag_type tag_ff [DEPTH];
   assign advance   = !vld_ff[DEPTH-1] || sl_ready;
   assign req.ready = advance;
   assign sl_valid  = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req.valid;
         for (int s = 1; s < DEPTH; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= '{has_phase: prev_valid_ff, last: req.last_of_burst};
         for (int s = 1; s < DEPTH; s++) tag_ff[s] <= tag_ff[s-1];
      end
   end

   // The previous sample is kept until the burst ends.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         prev_i_ff <= '0;
         prev_q_ff <= '0;
      end else if (req.valid && req.ready) begin
         prev_valid_ff <= !req.last_of_burst;
         prev_i_ff <= req.i_sample;
         prev_q_ff <= req.q_sample;
      end
   end

   // Stage 0: four products of x and the previous sample.
   logic signed [2*SAMPLE_WIDTH-1:0] ii_ff, qq_ff, qi_ff, iq_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         ii_ff <= req.i_sample * prev_i_ff;
         qq_ff <= req.q_sample * prev_q_ff;
         qi_ff <= req.q_sample * prev_i_ff;
         iq_ff <= req.i_sample * prev_q_ff;
      end
   end

   // Stage 1: real and imaginary part, rotation into the right half-plane.
   logic signed [PW-1:0] re, im;
   logic signed [VW-1:0] x0_ff, y0_ff;
   fmds_pkg::angle_type  z0_ff;
   assign re = PW'(ii_ff) + PW'(qq_ff);
   assign im = PW'(qi_ff) - PW'(iq_ff);
   always_ff @(posedge clock) begin
      if (advance) begin
         if (re[PW-1] && !im[PW-1]) begin
            x0_ff <= VW'(im); y0_ff <= -VW'(re); z0_ff <= fmds_pkg::QUARTER_TURN;
         end else if (re[PW-1]) begin
            x0_ff <= -VW'(im); y0_ff <= VW'(re); z0_ff <= -fmds_pkg::QUARTER_TURN;
         end else begin
            x0_ff <= VW'(re); y0_ff <= VW'(im); z0_ff <= '0;
         end
      end
   end

   // Row of CORDIC cells.
   logic signed [VW-1:0] xs [NS+1];
   logic signed [VW-1:0] ys [NS+1];
   fmds_pkg::angle_type  zs [NS+1];
   assign xs[0] = x0_ff;
   assign ys[0] = y0_ff;
   assign zs[0] = z0_ff;
   for (genvar k = 0; k < NS; k++) begin : g_cell
      fmds_cordic_cell #(.VEC_WIDTH(VW), .STAGE(k)) u_cell (
         .clock(clock), .advance(advance),
         .x_from(xs[k]), .y_from(ys[k]), .z_from(zs[k]),
         .x_out(xs[k+1]), .y_out(ys[k+1]), .z_out(zs[k+1]));
   end

   // A zero product has zero angle; pre-rotation maps it to z=0, y=0 which
   // would still rotate, so the zero flag rides along.
   logic zero_ff [NS+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= (re == '0) && (im == '0);
         for (int s = 1; s <= NS; s++) zero_ff[s] <= zero_ff[s-1];
      end
   end

   fmds_pkg::angle_type phase;
   assign phase = zero_ff[NS] ? '0 : zs[NS];

   fmds_slicer #(.SUM_WIDTH(SUM_WIDTH)) u_slicer (
      .clock(clock), .reset(reset), .sps_cfg(sps_ff),
      .in_valid(sl_valid), .in_phase(phase), .in_tag(tag_ff[DEPTH-1]),
      .in_ready(sl_ready), .rsp(rsp));

   // Assertions.
   a_eob_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.end_of_burst |-> rsp.last_of_run)
      else $error("end_of_burst without last_of_run");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      sl_valid && !sl_ready |=> sl_valid && $stable(phase))
      else $error("slicer input changed while stalled");
   a_no_phase_first: assert property (@(posedge clock) disable iff (reset)
      $past(req.valid && req.ready && req.last_of_burst) |-> !prev_valid_ff)
      else $error("previous sample kept across burst end");

endmodule

[tb/sv/tb_fm_discriminator_symbol_slicer_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_fm_discriminator_symbol_slicer_core: self-checking bench for the slicer
// Sends bursts of I/Q requests with random gaps, predicts the sliced symbols
// with a behavioral discriminator and slicer, and compares every result
// field by field in order. Results are drained with random stalls.
// ============================================================================
module tb_fm_discriminator_symbol_slicer_core;

   localparam int CLOCK_HALF  = 4;
   localparam int DRAIN_WAIT  = fmds_pkg::CORDIC_STAGES_DEF + 12;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic                 bit_res;
      logic signed [23:0]   soft_sum;
      logic                 last_of_run;
      logic                 end_of_burst;
   } symbol_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [fmds_pkg::SPS_WIDTH-1:0] csr_write_data = '0;

   fmds_req_if req ();
   fmds_rsp_if rsp ();

   fm_discriminator_symbol_slicer_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req.sink),
      .rsp              (rsp.source)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Predictor state.
   int unsigned   sym_rate;
   longint        last_i, last_q, last_phase, run_sum, held_sum;
   bit            have_iq, have_phase, have_held;
   int unsigned   run_count;
   symbol_type    expected_symbols[$];
   int            error_count = 0;
   int            cycle_count = 0;

   // Rounded atan(2^-k), pi = 32768.
   function automatic longint atan_step(input int k);
      longint tab [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                           10, 5, 3, 1, 1};
      return tab[k];
   endfunction

   function automatic longint shift_floor(input longint v, input int k);
      return v >>> k;
   endfunction

   function automatic longint clamp_sum(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // Vectoring CORDIC on the conjugate product.
   function automatic longint phase_of(input longint re, input longint im);
      longint x, y, z, t;
      logic signed [15:0] w;
      x = re; y = im; z = 0;
      if (re == 0 && im == 0) return 0;
      if (re < 0) begin
         if (im >= 0) begin
            x = im; y = -re; z = 16384;
         end else begin
            x = -im; y = re; z = -16384;
         end
      end
      for (int k = 0; k < fmds_pkg::CORDIC_STAGES_DEF; k++) begin
         if (y >= 0) begin
            t = x + shift_floor(y, k); y = y - shift_floor(x, k); x = t;
            z += atan_step(k);
         end else begin
            t = x - shift_floor(y, k); y = y + shift_floor(x, k); x = t;
            z -= atan_step(k);
         end
      end
      w = z[15:0];
      return longint'(w);
   endfunction

   function automatic void clear_run();
      last_i = 0; last_q = 0; have_iq = 0;
      last_phase = 0; have_phase = 0;
      run_sum = 0; run_count = 0;
      held_sum = 0; have_held = 0;
   endfunction

   function automatic void push_symbol(input longint s);
      symbol_type r;
      r.bit_res = (s >= 0);
      r.soft_sum = s[23:0];
      r.last_of_run = 0;
      r.end_of_burst = 0;
      expected_symbols.push_back(r);
   endfunction

   // Predicts the symbols one request gives.
   function automatic void predict_symbols(input longint xi, input longint xq,
                                           input bit last);
      int unsigned rate;
      int          n0;
      longint      re, im, p;
      rate = (sym_rate == 0) ? 1 : sym_rate;
      n0 = expected_symbols.size();
      if (have_iq) begin
         re = xi * last_i + xq * last_q;
         im = xq * last_i - xi * last_q;
         p = phase_of(re, im);
         // A sign change closes the run.
         if (have_phase && ((p > 0 && last_phase <= 0) || (p < 0 && last_phase >= 0))) begin
            if (run_count == 1 && have_held) begin
               held_sum = clamp_sum(held_sum + run_sum);
            end else begin
               if (have_held) push_symbol(held_sum);
               held_sum = run_sum;
               have_held = 1;
            end
            run_sum = 0; run_count = 0;
         end
         if (run_count >= rate) begin
            if (have_held) push_symbol(held_sum);
            held_sum = run_sum; have_held = 1;
            run_sum = 0; run_count = 0;
         end
         run_sum = clamp_sum(run_sum + p);
         run_count = (run_count + 1) & 6'h3f;
         last_phase = p; have_phase = 1;
      end
      last_i = xi; last_q = xq; have_iq = 1;
      if (last) begin
         if (have_held) push_symbol(held_sum);
         if (run_count > 0) push_symbol(run_sum);
         if (expected_symbols.size() > n0)
            expected_symbols[$].end_of_burst = 1;
         clear_run();
      end
      if (expected_symbols.size() > n0)
         expected_symbols[$].last_of_run = 1;
   endfunction

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Result side: random stalls and in-order compare.
   initial begin
      symbol_type w;
      int stall;
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         if ($urandom_range(0, 9) < 3) stall = 0;
         repeat (stall) begin
            rsp.ready <= 1'b0;
            @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         if (expected_symbols.size() == 0) begin
            report_mismatch("unexpected symbol, soft_sum", rsp.soft_sum, 0);
         end else begin
            w = expected_symbols.pop_front();
            if (rsp.bit_res !== w.bit_res)
               report_mismatch("bit_res", rsp.bit_res, w.bit_res);
            if (rsp.soft_sum !== w.soft_sum)
               report_mismatch("soft_sum", rsp.soft_sum, w.soft_sum);
            if (rsp.last_of_run !== w.last_of_run)
               report_mismatch("last_of_run", rsp.last_of_run, w.last_of_run);
            if (rsp.end_of_burst !== w.end_of_burst)
               report_mismatch("end_of_burst", rsp.end_of_burst, w.end_of_burst);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_fm_discriminator_symbol_slicer_core NOT OK");
         $finish;
      end
   end

   // Sends one request after a random gap. Valid stays high after the
   // handshake so that a following request can go out back to back.
   task automatic send_request(input logic signed [15:0] xi,
                               input logic signed [15:0] xq, input bit last);
      int gap;
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.i_sample <= xi;
      req.q_sample <= xq;
      req.last_of_burst <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_symbols(longint'(xi), longint'(xq), last);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_rate(input logic [fmds_pkg::SPS_WIDTH-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sym_rate = 32'(v);
   endtask

   // Rotating phasor with a chosen step, so runs have a known sign.
   task automatic send_tone(input int n, input real step, input real amp,
                            input bit end_burst);
      real a;
      a = $urandom_range(0, 628) / 100.0;
      for (int k = 0; k < n; k++) begin
         send_request(16'($rtoi(amp * $cos(a))), 16'($rtoi(amp * $sin(a))),
                      end_burst && k == n - 1);
         a += step;
      end
   endtask

   task automatic test_extremes();
      send_request(16'sh7fff, 16'sh7fff, 1'b0);
      send_request(-16'sh8000, 16'sh7fff, 1'b0);
      send_request(-16'sh8000, -16'sh8000, 1'b0);
      send_request(16'sh7fff, -16'sh8000, 1'b0);
      send_request(16'sd0, 16'sd0, 1'b0);
      send_request(16'sd0, 16'sd0, 1'b0);
      send_request(16'sh5555, -16'sh2aab, 1'b0);
      send_request(-16'sh8000, 16'sd0, 1'b0);
      send_request(16'sh7fff, 16'sd0, 1'b1);
      // Burst of one sample gives nothing.
      send_request(16'sh1234, -16'sh0fed, 1'b1);
      wait_idle();
   endtask

   task automatic test_sign_changes();
      // Alternating direction with single-phase tails.
      send_tone(4, 0.4, 20000.0, 1'b0);
      send_tone(3, -0.3, 20000.0, 1'b0);
      send_tone(2, 0.5, 20000.0, 1'b0);
      send_tone(5, -0.2, 20000.0, 1'b1);
      wait_idle();
   endtask

   // Random bursts of well-formed tones, plus noise.
   task automatic test_random_bursts(input int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         n = $urandom_range(1, 6);
         if ($urandom_range(0, 4) == 0) begin
            repeat (n) send_request(16'($urandom), 16'($urandom), 1'b0);
         end else begin
            send_tone(n, ($urandom_range(0, 1) ? 1.0 : -1.0) *
                      $urandom_range(1, 150) / 100.0,
                      $urandom_range(100, 32000), 1'b0);
         end
         sent += n;
         if ($urandom_range(0, 3) == 0) begin
            send_request(16'($urandom), 16'($urandom), 1'b1);
            sent++;
         end
      end
      send_request(16'($urandom), 16'($urandom), 1'b1);
      wait_idle();
   endtask

   initial begin
      req.valid <= 1'b0;
      req.i_sample <= '0;
      req.q_sample <= '0;
      req.last_of_burst <= 1'b0;
      sym_rate = 32'(fmds_pkg::SPS_RESET);
      clear_run();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_sign_changes();
      write_rate(6'd1);
      test_sign_changes();
      test_random_bursts(25);
      write_rate(6'd0);
      test_random_bursts(15);
      write_rate(6'd32);
      send_tone(40, 0.3, 25000.0, 1'b1);
      wait_idle();
      write_rate(6'd63);
      test_random_bursts(10);
      write_rate(6'd3);
      test_random_bursts(25);
      write_rate(6'd2);
      test_random_bursts(10);
      if (error_count == 0) begin
         $display("tb_fm_discriminator_symbol_slicer_core OK");
      end else begin
         $display("tb_fm_discriminator_symbol_slicer_core NOT OK");
      end
      $finish;
   end

endmodule
